[src/dart_pkg.sv]
// Shared widths, register indexes, types and the timer rate table.
package dart_pkg;

   localparam int CyclesWidth  = 8;
   localparam int CountWidth   = 8;
   localparam int SelectWidth  = 2;
   localparam int CsrIdxWidth  = 2;
   localparam int CsrDataWidth = 8;
   localparam int DivPreWidth  = 8;    // divider prescale always stays below 256
   localparam int TmrPreWidth  = 10;   // timer prescale always stays below 1024
   localparam int TmrSumWidth  = TmrPreWidth + 1;

   localparam logic [CountWidth-1:0] CountMax = '1;

   localparam logic [CsrIdxWidth-1:0] CsrTimerEnable = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CsrClockSelect = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CsrReloadValue = 2'd2;

   localparam logic [SelectWidth-1:0] SelRate1024 = 2'd0;
   localparam logic [SelectWidth-1:0] SelRate16   = 2'd1;
   localparam logic [SelectWidth-1:0] SelRate64   = 2'd2;
   localparam logic [SelectWidth-1:0] SelRate256  = 2'd3;

   typedef struct packed {
      logic                   timer_enable;
      logic [SelectWidth-1:0] clock_select;
      logic [CountWidth-1:0]  reload_value;
   } cfg_type;

   typedef struct packed {
      logic [DivPreWidth-1:0] divider_prescale;
      logic [CountWidth-1:0]  divider_count;
      logic [TmrPreWidth-1:0] timer_prescale;
      logic [SelectWidth-1:0] seen_select;
      logic [CountWidth-1:0]  timer_count;
   } state_type;

   typedef struct packed {
      logic [CountWidth-1:0] divider_value;
      logic [CountWidth-1:0] timer_value;
      logic                  overflow_irq;
   } result_type;

   // cycles per timer count for each select code
   function automatic logic [TmrSumWidth-1:0] rate_threshold(
      input logic [SelectWidth-1:0] sel);
      logic [TmrSumWidth-1:0] thr;
      begin
         unique case (sel)
            SelRate1024: thr = 11'd1024;
            SelRate16:   thr = 11'd16;
            SelRate64:   thr = 11'd64;
            SelRate256:  thr = 11'd256;
            default:     thr = 11'd1024;
         endcase
         return thr;
      end
   endfunction

endpackage

[src/dart_if.sv]
// Valid/ready channel interfaces: time step input, result output, register writes.
interface dart_req_if;
   logic                               valid;
   logic                               ready;
   logic [dart_pkg::CyclesWidth-1:0]   elapsed_cycles;

   modport source (output valid, output elapsed_cycles, input ready);
   modport sink   (input valid, input elapsed_cycles, output ready);
endinterface

interface dart_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [dart_pkg::CountWidth-1:0]    divider_value;
   logic [dart_pkg::CountWidth-1:0]    timer_value;
   logic                               overflow_irq;

   modport source (output valid, output divider_value, output timer_value,
                   output overflow_irq, input ready);
   modport sink   (input valid, input divider_value, input timer_value,
                   input overflow_irq, output ready);
endinterface

interface dart_csr_if;
   logic                               valid;
   logic                               ready;
   logic [dart_pkg::CsrIdxWidth-1:0]   index;
   logic [dart_pkg::CsrDataWidth-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[src/dart_step.sv]
// Next-state logic for one time step: divider and timer update.
module dart_step (
   input  dart_pkg::state_type                cur,
   input  dart_pkg::cfg_type                  cfg,
   input  logic [dart_pkg::CyclesWidth-1:0]   cycles,
   output dart_pkg::state_type                nxt,
   output dart_pkg::result_type               res
);

   logic [dart_pkg::DivPreWidth:0]     div_sum;
   logic [dart_pkg::TmrSumWidth-1:0]   tmr_sum;
   logic                               tmr_hit;
   logic                               irq;

   assign div_sum = {1'b0, cur.divider_prescale} + {1'b0, cycles};
   assign tmr_sum = {1'b0, cur.timer_prescale}
                  + {{(dart_pkg::TmrSumWidth - dart_pkg::CyclesWidth){1'b0}}, cycles};
   assign tmr_hit = tmr_sum >= dart_pkg::rate_threshold(cur.seen_select);

   always_comb begin
      nxt = cur;
      irq = 1'b0;

      // divider: carry out of the 8-bit prescale means 256 reached
      if (div_sum[dart_pkg::DivPreWidth]) begin
         nxt.divider_prescale = '0;
         nxt.divider_count    = cur.divider_count + 1'b1;
      end else begin
         nxt.divider_prescale = div_sum[dart_pkg::DivPreWidth-1:0];
      end

      if (cur.seen_select != cfg.clock_select) begin
         nxt.seen_select    = cfg.clock_select;
         nxt.timer_prescale = '0;
      end else if (cfg.timer_enable) begin
         if (tmr_hit) begin
            nxt.timer_prescale = '0;
            if (cur.timer_count == dart_pkg::CountMax) begin
               nxt.timer_count = cfg.reload_value;
               irq             = 1'b1;
            end else begin
               nxt.timer_count = cur.timer_count + 1'b1;
            end
         end else begin
            // below threshold, so it fits the stored width
            nxt.timer_prescale = tmr_sum[dart_pkg::TmrPreWidth-1:0];
         end
      end
   end

   assign res.divider_value = nxt.divider_count;
   assign res.timer_value   = nxt.timer_count;
   assign res.overflow_irq  = irq;

endmodule

[src/divider_and_reload_timer.sv]
// Top level: divider and reload timer with valid/ready channels.
// Each req item is one time step of elapsed_cycles machine cycles. The block
// takes one item per clock while rsp is not stalled: an item is held in an
// input register, the step logic (one 9-bit and one 11-bit add with a threshold
// compare) works on the held item, and the counters and the result register
// update together when the result register is free or being emptied. The result
// register and the input register together let a new item come in while a
// result is still waiting for rsp ready; with rsp stalled, two items are
// held before req ready drops. Registers (timer_enable, clock_select,
// reload_value) are written through csr, which is always ready; a write
// to an index past the list is ignored.
module divider_and_reload_timer (
   input  logic          clock,
   input  logic          reset,
   dart_req_if.sink      req_chan,
   dart_rsp_if.source    rsp_chan,
   dart_csr_if.sink      csr_chan
);

   // register file
   dart_pkg::cfg_type                    cfg_ff;

   // input stage
   logic                                 s1_valid_ff;
   logic [dart_pkg::CyclesWidth-1:0]     s1_cycles_ff;

   // counters
   dart_pkg::state_type                  state_ff;
   dart_pkg::state_type                  state_in;

   // result stage
   logic                                 rsp_valid_ff;
   dart_pkg::result_type                 rsp_ff;
   dart_pkg::result_type                 rsp_in;

   logic                                 s1_advance;
   logic                                 req_take;

   // stage 1 moves on when the result register is free or being emptied
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign req_take = req_chan.valid && req_chan.ready;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            dart_pkg::CsrTimerEnable: cfg_ff.timer_enable <= csr_chan.data[0];
            dart_pkg::CsrClockSelect:
               cfg_ff.clock_select <= csr_chan.data[dart_pkg::SelectWidth-1:0];
            dart_pkg::CsrReloadValue:
               cfg_ff.reload_value <= csr_chan.data[dart_pkg::CountWidth-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_cycles_ff <= req_chan.elapsed_cycles;
      end
   end

   dart_step u_step (
      .cur    (state_ff),
      .cfg    (cfg_ff),
      .cycles (s1_cycles_ff),
      .nxt    (state_in),
      .res    (rsp_in)
   );

   // counter state commits only when the step's result is registered
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (s1_advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.divider_value = rsp_ff.divider_value;
   assign rsp_chan.timer_value   = rsp_ff.timer_value;
   assign rsp_chan.overflow_irq  = rsp_ff.overflow_irq;

endmodule

[src/dart_chk.sv]
// Port-level checker for the divider and reload timer, with its bind.
module dart_chk (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [dart_pkg::CountWidth-1:0]   divider_value,
   input logic [dart_pkg::CountWidth-1:0]   timer_value,
   input logic                              overflow_irq,
   input logic                              csr_valid,
   input logic                              csr_ready,
   input logic [dart_pkg::CsrIdxWidth-1:0]  csr_index,
   input logic [dart_pkg::CsrDataWidth-1:0] csr_data
);

   logic                              en_ff;
   logic [dart_pkg::CountWidth-1:0]   div_last_ff;
   logic [dart_pkg::CountWidth-1:0]   tmr_last_ff;
   logic                              rsp_take;

   assign rsp_take = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff <= 1'b0;
      end else if (csr_valid && csr_ready && csr_index == dart_pkg::CsrTimerEnable) begin
         en_ff <= csr_data[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_last_ff <= '0;
         tmr_last_ff <= '0;
      end else if (rsp_take) begin
         div_last_ff <= divider_value;
         tmr_last_ff <= timer_value;
      end
   end

   // no result straight out of reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(divider_value)
         && $stable(timer_value) && $stable(overflow_irq))
      else $error("stalled result changed");

   // divider counts at most once per item
   a_div_step: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> divider_value == div_last_ff
         || divider_value == div_last_ff + 1'b1)
      else $error("divider jumped by more than one");

   // stopped timer neither moves nor overflows
   a_tmr_stopped: assert property (@(posedge clock) disable iff (reset)
      rsp_take && !en_ff |-> timer_value == tmr_last_ff && !overflow_irq)
      else $error("timer moved while disabled");

endmodule

bind divider_and_reload_timer dart_chk u_dart_chk (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .divider_value (rsp_chan.divider_value),
   .timer_value   (rsp_chan.timer_value),
   .overflow_irq  (rsp_chan.overflow_irq),
   .csr_valid     (csr_chan.valid),
   .csr_ready     (csr_chan.ready),
   .csr_index     (csr_chan.index),
   .csr_data      (csr_chan.data)
);

[tb/sv/divider_and_reload_timer_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the divider and reload timer: directed table, then random phases.
module divider_and_reload_timer_tb;

   localparam int CycleLimit = 400_000;  // far above the slowest legal run
   localparam int RandomItems = 370;
   localparam int TailItems = 40;       // final stretch with no idling
   localparam int ReportLimit = 10;

   // index 3 maps to no register; the block must drop such writes
   localparam logic [dart_pkg::CsrIdxWidth-1:0] CsrNoReg = 2'd3;

   typedef enum bit {RowStep, RowWrite} row_kind_type;

   typedef struct {
      row_kind_type                      kind;
      logic [dart_pkg::CsrIdxWidth-1:0]  index;   // writes only
      logic [dart_pkg::CsrDataWidth-1:0] value;   // elapsed cycles or write data
      bit                                typed;   // expected result written out below
      dart_pkg::result_type              want;    // {divider, timer, irq}
   } plan_row_type;

   localparam int PlanRows = 36;

   // Directed table. Rows with typed = 1 carry a result worked out by hand;
   // the rest are checked against the predictor.
   plan_row_type directed_plan [PlanRows] = '{
      // after reset: divider runs, timer is off
      '{RowStep,  CsrNoReg,                 8'd0,   1'b1, {8'd0, 8'd0, 1'b0}},
      '{RowStep,  CsrNoReg,                 8'd255, 1'b1, {8'd0, 8'd0, 1'b0}},
      '{RowStep,  CsrNoReg,                 8'd1,   1'b1, {8'd1, 8'd0, 1'b0}},  // hits 256
      '{RowStep,  CsrNoReg,                 8'd255, 1'b1, {8'd1, 8'd0, 1'b0}},
      '{RowStep,  CsrNoReg,                 8'd255, 1'b1, {8'd2, 8'd0, 1'b0}},  // excess dropped
      // upper data bits set: only the low bits count
      '{RowWrite, dart_pkg::CsrTimerEnable, 8'hFF,  1'b0, '0},
      '{RowWrite, dart_pkg::CsrClockSelect, 8'hFD,  1'b0, '0},                  // rate 16
      '{RowWrite, dart_pkg::CsrReloadValue, 8'hF0,  1'b0, '0},
      '{RowStep,  CsrNoReg,                 8'd16,  1'b1, {8'd2, 8'd0, 1'b0}},  // select change
      '{RowStep,  CsrNoReg,                 8'd15,  1'b1, {8'd2, 8'd0, 1'b0}},
      '{RowStep,  CsrNoReg,                 8'd1,   1'b1, {8'd2, 8'd1, 1'b0}},
      '{RowStep,  CsrNoReg,                 8'd255, 1'b1, {8'd3, 8'd2, 1'b0}},  // one count only
      '{RowWrite, dart_pkg::CsrClockSelect, 8'h02,  1'b0, '0},                  // rate 64
      '{RowStep,  CsrNoReg,                 8'd100, 1'b1, {8'd3, 8'd2, 1'b0}},
      '{RowStep,  CsrNoReg,                 8'd63,  1'b0, '0},
      '{RowStep,  CsrNoReg,                 8'd1,   1'b0, '0},
      // disabled timer still tracks a select change
      '{RowWrite, dart_pkg::CsrTimerEnable, 8'hFE,  1'b0, '0},
      '{RowWrite, dart_pkg::CsrClockSelect, 8'h03,  1'b0, '0},                  // rate 256
      '{RowStep,  CsrNoReg,                 8'd200, 1'b0, '0},
      '{RowStep,  CsrNoReg,                 8'd255, 1'b0, '0},
      '{RowWrite, dart_pkg::CsrTimerEnable, 8'h01,  1'b0, '0},
      '{RowStep,  CsrNoReg,                 8'd255, 1'b0, '0},
      '{RowStep,  CsrNoReg,                 8'd1,   1'b0, '0},
      '{RowWrite, dart_pkg::CsrClockSelect, 8'h00,  1'b0, '0},                  // rate 1024
      '{RowStep,  CsrNoReg,                 8'd0,   1'b0, '0},
      '{RowStep,  CsrNoReg,                 8'd255, 1'b0, '0},
      '{RowStep,  CsrNoReg,                 8'd255, 1'b0, '0},
      '{RowStep,  CsrNoReg,                 8'd255, 1'b0, '0},
      '{RowStep,  CsrNoReg,                 8'd255, 1'b0, '0},
      '{RowStep,  CsrNoReg,                 8'd4,   1'b0, '0},                  // reaches 1024
      // same select rewritten: no skip
      '{RowWrite, dart_pkg::CsrClockSelect, 8'hFC,  1'b0, '0},
      '{RowStep,  CsrNoReg,                 8'd255, 1'b0, '0},
      '{RowWrite, CsrNoReg,                 8'hFF,  1'b0, '0},
      '{RowStep,  CsrNoReg,                 8'd0,   1'b0, '0},
      '{RowWrite, dart_pkg::CsrReloadValue, 8'h00,  1'b0, '0},
      '{RowStep,  CsrNoReg,                 8'd128, 1'b0, '0}
   };

   logic clock = 1'b0;
   logic reset;

   dart_req_if req_chan ();
   dart_rsp_if rsp_chan ();
   dart_csr_if csr_chan ();

   divider_and_reload_timer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #5 clock = ~clock;

   // Predictor state, mirrors the block's registers and counters
   logic                              en_reg = 1'b0;
   logic [dart_pkg::SelectWidth-1:0]  sel_reg = dart_pkg::SelRate1024;
   logic [dart_pkg::CountWidth-1:0]   reload_reg = '0;
   logic [9:0]                        div_prescale = '0;
   logic [dart_pkg::CountWidth-1:0]   div_count = '0;
   logic [10:0]                       tmr_prescale = '0;
   logic [dart_pkg::SelectWidth-1:0]  rate_seen = dart_pkg::SelRate1024;
   logic [dart_pkg::CountWidth-1:0]   tmr_count = '0;

   dart_pkg::result_type expected_results[$];
   int unsigned steps_sent = 0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned req_gaps = 0;    // 0 none, 1 light, 2 heavy
   int unsigned rsp_mode = 0;
   int unsigned rsp_hold = 0;
   bit          steady = 1'b0;   // no idling on either side

   // One time step of the divider and timer; returns the result it produces.
   function automatic dart_pkg::result_type advance_timer(
      input logic [dart_pkg::CyclesWidth-1:0] cyc);
      dart_pkg::result_type res;
      logic [10:0] period;
      res.overflow_irq = 1'b0;
      div_prescale = div_prescale + cyc;
      if (div_prescale >= 10'd256) begin
         div_prescale = '0;
         div_count = div_count + 1'b1;
      end
      if (rate_seen != sel_reg) begin
         // new rate: restart prescale, no timer count this step
         rate_seen = sel_reg;
         tmr_prescale = '0;
      end else if (en_reg) begin
         case (rate_seen)
            dart_pkg::SelRate16:  period = 11'd16;
            dart_pkg::SelRate64:  period = 11'd64;
            dart_pkg::SelRate256: period = 11'd256;
            default:              period = 11'd1024;
         endcase
         tmr_prescale = tmr_prescale + cyc;
         if (tmr_prescale >= period) begin
            tmr_prescale = '0;
            if (tmr_count == dart_pkg::CountMax) begin
               tmr_count = reload_reg;
               res.overflow_irq = 1'b1;
            end else begin
               tmr_count = tmr_count + 1'b1;
            end
         end
      end
      res.divider_value = div_count;
      res.timer_value = tmr_count;
      return res;
   endfunction

   function automatic void flag_error(input string msg);
      error_count++;
      if (error_count <= ReportLimit) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
   endfunction

   // Present one item and log its expected result once taken. Leaves valid
   // high, unless it inserts a random gap, so back-to-back items need no lowering in between.
   task automatic send_step(input logic [dart_pkg::CyclesWidth-1:0] cyc, input bit typed,
                            input dart_pkg::result_type want);
      dart_pkg::result_type predicted;
      int unsigned gap;
      csr_chan.valid <= 1'b0;
      req_chan.valid <= 1'b1;
      req_chan.elapsed_cycles <= cyc;
      do @(posedge clock); while (!req_chan.ready);
      predicted = advance_timer(cyc);
      expected_results.push_back(typed ? want : predicted);
      steps_sent++;
      if (!steady && req_gaps != 0 && $urandom_range(0, req_gaps == 2 ? 2 : 7) == 0) begin
         gap = $urandom_range(1, 8);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Registers change only once every result has come back.
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [dart_pkg::CsrIdxWidth-1:0] idx,
                            input logic [dart_pkg::CsrDataWidth-1:0] data);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data <= data;
      do @(posedge clock); while (!csr_chan.ready);
      case (idx)
         dart_pkg::CsrTimerEnable: en_reg = data[0];
         dart_pkg::CsrClockSelect: sel_reg = data[dart_pkg::SelectWidth-1:0];
         dart_pkg::CsrReloadValue: reload_reg = data;
         default: ;
      endcase
   endtask

   // Result side: random ready stalls, checking, cycle limit
   always @(posedge clock) begin
      dart_pkg::result_type got;
      dart_pkg::result_type want;
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("TEST FAILED");
         $finish;
      end
      // stall pattern redrawn: none, light or heavy
      if (cycle_count % 64 == 0) begin
         rsp_mode = $urandom_range(0, 2);
      end
      if (rsp_hold != 0) begin
         rsp_hold--;
      end else if (!steady && rsp_mode != 0 &&
                   $urandom_range(0, rsp_mode == 2 ? 2 : 7) == 0) begin
         rsp_hold = $urandom_range(1, 8);
      end
      rsp_chan.ready <= (rsp_hold == 0);

      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = {rsp_chan.divider_value, rsp_chan.timer_value, rsp_chan.overflow_irq};
         if (expected_results.size() == 0) begin
            flag_error($sformatf("unexpected item %p", got));
         end else begin
            want = expected_results.pop_front();
            if (got.divider_value !== want.divider_value) begin
               flag_error($sformatf("divider_value exp %0d got %0d",
                                    want.divider_value, got.divider_value));
            end
            if (got.timer_value !== want.timer_value) begin
               flag_error($sformatf("timer_value exp %0d got %0d",
                                    want.timer_value, got.timer_value));
            end
            if (got.overflow_irq !== want.overflow_irq) begin
               flag_error($sformatf("overflow_irq exp %0b got %0b",
                                    want.overflow_irq, got.overflow_irq));
            end
         end
      end
   end

   // Stimulus
   initial begin
      int unsigned phase_len;
      int unsigned random_steps;
      logic [dart_pkg::CsrDataWidth-1:0] data;
      logic [dart_pkg::CyclesWidth-1:0] cyc;

      req_chan.valid <= 1'b0;
      req_chan.elapsed_cycles <= '0;
      csr_chan.valid <= 1'b0;
      csr_chan.index <= dart_pkg::CsrTimerEnable;
      csr_chan.data <= '0;
      reset <= 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed table
      req_gaps = $urandom_range(0, 2);
      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == RowWrite) begin
            wait_idle();
            write_reg(directed_plan[i].index, directed_plan[i].value);
         end else begin
            send_step(directed_plan[i].value, directed_plan[i].typed, directed_plan[i].want);
         end
      end

      // random phases: new register settings, then a run of steps
      random_steps = 0;
      while (random_steps < RandomItems) begin
         wait_idle();
         req_gaps = $urandom_range(0, 2);
         if ($urandom_range(0, 2) != 0) begin
            data = dart_pkg::CsrDataWidth'($urandom());
            data[0] = ($urandom_range(0, 4) != 0);   // mostly enabled
            write_reg(dart_pkg::CsrTimerEnable, data);
         end
         if ($urandom_range(0, 2) != 0) begin
            data = dart_pkg::CsrDataWidth'($urandom());
            // lean on the fastest rate so overflows come often
            if ($urandom_range(0, 1) != 0) begin
               data[dart_pkg::SelectWidth-1:0] = dart_pkg::SelRate16;
            end
            write_reg(dart_pkg::CsrClockSelect, data);
         end
         if ($urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 5))
               0:       data = '0;
               1:       data = '1;
               2, 3:    data = dart_pkg::CsrDataWidth'($urandom_range(8'hE0, 8'hFF));
               default: data = dart_pkg::CsrDataWidth'($urandom());
            endcase
            write_reg(dart_pkg::CsrReloadValue, data);
         end
         if ($urandom_range(0, 7) == 0) begin
            data = dart_pkg::CsrDataWidth'($urandom());
            write_reg(CsrNoReg, data);
         end
         phase_len = $urandom_range(10, 50);
         repeat (phase_len) begin
            case ($urandom_range(0, 7))
               4:       cyc = dart_pkg::CyclesWidth'($urandom_range(0, 24));
               5, 6:    cyc = dart_pkg::CyclesWidth'($urandom_range(200, 255));
               7:       cyc = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
               default: cyc = dart_pkg::CyclesWidth'($urandom_range(0, 255));
            endcase
            send_step(cyc, 1'b0, '0);
            random_steps++;
         end
      end

      // closing stretch at full rate on both sides
      steady = 1'b1;
      repeat (TailItems) begin
         cyc = dart_pkg::CyclesWidth'($urandom());
         send_step(cyc, 1'b0, '0);
      end
      req_chan.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (error_count == 0 && expected_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
src/dart_pkg.sv
src/dart_if.sv
src/dart_step.sv
src/divider_and_reload_timer.sv
src/dart_chk.sv
tb/sv/divider_and_reload_timer_tb.sv
